// ===== design/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

    // Width of one colour channel and of every result field.
    localparam int CHANNEL_BITS = 8;

    // Working widths of the two dividers.
    // Saturation: dividend CHAN_MAX * chroma, divisor max.
    // Hue: dividend CHAN_MAX * num with num below 6 * chroma, divisor 6 * chroma.
    localparam int SAT_REM_W = 2 * CHANNEL_BITS;
    localparam int HUE_DSR_W = CHANNEL_BITS + 3;
    localparam int HUE_REM_W = 2 * CHANNEL_BITS + 3;

    // Which channel holds the maximum; ties resolve in red, green, blue order.
    localparam int SEL_W = 2;
    localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hue_out;
        logic [CHANNEL_BITS-1:0] sat_out;
        logic [CHANNEL_BITS-1:0] val_out;
    } hsv_t;

    // Contents of the first stage: channels, extremes and the max selector.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] chroma;
        logic [SEL_W-1:0]        sel;
    } prep_t;

    // Contents of one divider stage: partial remainders and quotients.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] val;
        logic [SAT_REM_W-1:0]    rem_s;
        logic [CHANNEL_BITS-1:0] quo_s;
        logic [CHANNEL_BITS-1:0] dsr_s;
        logic [HUE_REM_W-1:0]    rem_h;
        logic [CHANNEL_BITS-1:0] quo_h;
        logic [HUE_DSR_W-1:0]    dsr_h;
    } div_t;

endpackage

`default_nettype wire

// ===== design/rgb_to_hsv_converter.sv =====
`default_nettype none
// Throughput: one pixel per clock while the output is not stalled; the first stage
// computes max, min and chroma, the second forms the dividends and divisors, then
// each of CHANNEL_BITS stages resolves one quotient bit of both the hue and the
// saturation divider.
// Reset: aresetn is synchronous and active low; it clears all stage valid bits,
// so the pipeline comes out of reset empty and ready.

module rgb_to_hsv_converter (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rgbhsv_pkg::pixel_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rgbhsv_pkg::hsv_t         m_data
);

    import rgbhsv_pkg::*;

    localparam int NDIV = CHANNEL_BITS;

    // First stage: extremes of the pixel.
    prep_t prep_reg;
    prep_t prep_next;
    logic  prep_vld_reg;
    logic  prep_rdy;

    // Divider stages: index 0 holds the set-up operands, index j the state
    // after j quotient bits have been decided.
    div_t  div_reg [NDIV+1];
    div_t  div_next [NDIV+1];
    logic  vld_reg [NDIV+1];
    logic  rdy [NDIV+1];

    // Each stage may take a new request whenever it is empty or its content
    // moves on in the same cycle, so bubbles close up behind a stalled output.
    always_comb begin
        rdy[NDIV] = !vld_reg[NDIV] || m_ready;
        for (int j = NDIV - 1; j >= 0; j--) begin
            rdy[j] = !vld_reg[j] || rdy[j+1];
        end
        prep_rdy = !prep_vld_reg || rdy[0];
    end

    assign s_ready = prep_rdy;

    // Stage one: max with red, green, blue priority, min and chroma.
    always_comb begin
        logic [CHANNEL_BITS-1:0] r, g, b, mn;
        r = s_data.red_in;
        g = s_data.green_in;
        b = s_data.blue_in;
        prep_next.red   = r;
        prep_next.green = g;
        prep_next.blue  = b;
        if (r >= g && r >= b) begin
            prep_next.sel = SEL_RED;
            prep_next.mx  = r;
        end else if (g >= b) begin
            prep_next.sel = SEL_GREEN;
            prep_next.mx  = g;
        end else begin
            prep_next.sel = SEL_BLUE;
            prep_next.mx  = b;
        end
        if (r <= g && r <= b) begin
            mn = r;
        end else if (g <= b) begin
            mn = g;
        end else begin
            mn = b;
        end
        prep_next.chroma = prep_next.mx - mn;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (prep_rdy) begin
            prep_vld_reg <= s_valid;
        end
        if (prep_rdy) begin
            prep_reg <= prep_next;
        end
    end

    // Stage two: hue numerator, the scaled dividends and the divisors.
    // A zero divisor is replaced by one; its dividend is then zero as well,
    // which gives the black and gray results of zero hue and saturation.
    always_comb begin
        logic [HUE_DSR_W-1:0] c1, c2, c4, c6, rx, gx, bx, num;
        logic [SAT_REM_W-1:0] c_s;
        logic [HUE_REM_W-1:0] num_h;
        c1 = HUE_DSR_W'(prep_reg.chroma);
        rx = HUE_DSR_W'(prep_reg.red);
        gx = HUE_DSR_W'(prep_reg.green);
        bx = HUE_DSR_W'(prep_reg.blue);
        c2 = c1 << 1;
        c4 = c1 << 2;
        c6 = c4 + c2;
        case (prep_reg.sel)
            SEL_RED: begin
                if (bx > gx) begin
                    num = c6 - (bx - gx);
                end else begin
                    num = gx - bx;
                end
            end
            SEL_GREEN: begin
                if (bx >= rx) begin
                    num = c2 + (bx - rx);
                end else begin
                    num = c2 - (rx - bx);
                end
            end
            default: begin
                if (rx >= gx) begin
                    num = c4 + (rx - gx);
                end else begin
                    num = c4 - (gx - rx);
                end
            end
        endcase
        c_s   = SAT_REM_W'(prep_reg.chroma);
        num_h = HUE_REM_W'(num);
        div_next[0].val   = prep_reg.mx;
        div_next[0].rem_s = (c_s << CHANNEL_BITS) - c_s;
        div_next[0].quo_s = '0;
        div_next[0].dsr_s = (prep_reg.mx == '0) ? CHANNEL_BITS'(1) : prep_reg.mx;
        div_next[0].rem_h = (num_h << CHANNEL_BITS) - num_h;
        div_next[0].quo_h = '0;
        div_next[0].dsr_h = (prep_reg.chroma == '0) ? HUE_DSR_W'(1) : c6;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            vld_reg[0] <= prep_vld_reg;
        end
        if (rdy[0]) begin
            div_reg[0] <= div_next[0];
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    // Both quotients are known to fit in CHANNEL_BITS bits, so the divisor is
    // only ever shifted by CHANNEL_BITS - 1 places at most.
    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        localparam int K = NDIV - j;

        always_comb begin
            logic [SAT_REM_W-1:0] cand_s;
            logic [HUE_REM_W-1:0] cand_h;
            div_next[j] = div_reg[j-1];
            cand_s = SAT_REM_W'(div_reg[j-1].dsr_s) << K;
            cand_h = HUE_REM_W'(div_reg[j-1].dsr_h) << K;
            if (div_reg[j-1].rem_s >= cand_s) begin
                div_next[j].rem_s    = div_reg[j-1].rem_s - cand_s;
                div_next[j].quo_s[K] = 1'b1;
            end
            if (div_reg[j-1].rem_h >= cand_h) begin
                div_next[j].rem_h    = div_reg[j-1].rem_h - cand_h;
                div_next[j].quo_h[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                vld_reg[j] <= vld_reg[j-1];
            end
            if (rdy[j]) begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // The last divider stage is the output register.
    assign m_valid        = vld_reg[NDIV];
    assign m_data.hue_out = div_reg[NDIV].quo_h;
    assign m_data.sat_out = div_reg[NDIV].quo_s;
    assign m_data.val_out = div_reg[NDIV].val;

    // Zero saturation means zero chroma, and so the hue must be zero too.
    a_gray_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sat_out == '0 |-> m_data.hue_out == '0)
        else $error("nonzero hue on a pixel with zero saturation");

    // A finished division leaves both remainders below their divisors.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (div_reg[NDIV].rem_s < SAT_REM_W'(div_reg[NDIV].dsr_s))
                 && (div_reg[NDIV].rem_h < HUE_REM_W'(div_reg[NDIV].dsr_h)))
        else $error("divider remainder not below divisor");

    // A request leaving the first stage always lands in the divider set-up stage.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        prep_vld_reg && rdy[0] |=> vld_reg[0])
        else $error("request lost between first stage and divider");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import rgbhsv_pkg::*;

    // The result channel's ready follows its own pattern. It changes mode every so
    // often, so that stalls land on every stage of the divider pipeline.
    typedef enum logic [1:0] {
        SINK_OPEN,    // always ready
        SINK_COIN,    // ready about half of the time
        SINK_SPARSE,  // ready about a tenth of the time
        SINK_COMB     // fixed comb: held off two fifths of the time
    } sink_mode_e;

    // One pixel waiting to be sent. When drain_first is set, the sender holds
    // this pixel back until every result already owed has come out.
    typedef struct {
        pixel_t px;
        bit     drain_first;
    } pixel_job_t;

    localparam longint unsigned CHAN_MAX = (64'd1 << CHANNEL_BITS) - 1;
    localparam int              PIPE_DEPTH = CHANNEL_BITS + 2;
    localparam int              RANDOM_PIXELS = 1750;

    logic   aclk;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    pixel_t s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    hsv_t   m_data;

    pixel_job_t pixel_queue[$];
    hsv_t       expected_hsv[$];
    int         mismatch_count = 0;

    // Sender burst state: pixels left in the current burst and idle cycles to
    // wait before the next one.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall state.
    sink_mode_e sink_mode   = SINK_OPEN;
    int         sink_hold   = 0;
    int         comb_phase  = 0;

    rgb_to_hsv_converter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Expected hue, saturation and value of one pixel, computed with exact integer
    // arithmetic. Value is the largest channel and chroma the spread between the
    // largest and the smallest. The channel holding the maximum picks the hue
    // sector, with ties going to red first, then green. A black pixel gives all
    // zeros, and a gray one (no chroma) gives zero hue and zero saturation.
    function automatic hsv_t predict_hsv(pixel_t px);
        longint r, g, b;
        longint top, bottom, chroma, sector_num;
        longint unsigned hue, sat;
        hsv_t res;
        r = longint'(px.red_in);
        g = longint'(px.green_in);
        b = longint'(px.blue_in);
        top    = r;
        bottom = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        chroma = top - bottom;
        hue = 0;
        sat = 0;
        if (top != 0) begin
            sat = (CHAN_MAX * chroma) / top;
            if (chroma != 0) begin
                // Position around the circle in units of one sixth of chroma;
                // never negative, since the red sector wraps past the top.
                if (top == r) begin
                    sector_num = (b > g) ? 6 * chroma - (b - g) : g - b;
                end else if (top == g) begin
                    sector_num = 2 * chroma + b - r;
                end else begin
                    sector_num = 4 * chroma + r - g;
                end
                hue = (CHAN_MAX * sector_num) / (6 * chroma);
            end
        end
        res.hue_out = hue[CHANNEL_BITS-1:0];
        res.sat_out = sat[CHANNEL_BITS-1:0];
        res.val_out = top[CHANNEL_BITS-1:0];
        return res;
    endfunction

    task automatic add_pixel(input longint unsigned r, g, b, input bit drain_first = 1'b0);
        pixel_job_t job;
        job.px.red_in   = r[CHANNEL_BITS-1:0];
        job.px.green_in = g[CHANNEL_BITS-1:0];
        job.px.blue_in  = b[CHANNEL_BITS-1:0];
        job.drain_first = drain_first;
        pixel_queue.push_back(job);
    endtask

    function automatic longint unsigned rand_chan();
        return 64'($urandom_range(0, int'(CHAN_MAX)));
    endfunction

    // Channel values from the edges of the range, or anywhere now and then.
    function automatic longint unsigned edge_chan();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return CHAN_MAX - 1;
            3: return CHAN_MAX;
            default: return rand_chan();
        endcase
    endfunction

    // Driver. A request is taken at any edge where valid and ready are both high;
    // its expected result is queued at that very edge. Once valid is raised it
    // stays up with the same pixel until the request is taken.
    always @(posedge aclk) begin : pixel_driver
        bit holding;
        bit send_now;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            holding = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                expected_hsv.push_back(predict_hsv(s_data));
            end
            if (!holding) begin
                send_now = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pixel_queue.size() > 0 &&
                             (!pixel_queue[0].drain_first || expected_hsv.size() == 0)) begin
                    send_now = 1'b1;
                end
                if (send_now) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_queue[0].px;
                    pixel_queue.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        // New burst length; one gap in four is skipped altogether
                        // so that long back-to-back stretches occur as well.
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, independent of the sender.
    always @(posedge aclk) begin : sink_pattern
        if (sink_hold == 0) begin
            sink_mode = sink_mode_e'($urandom_range(0, 3));
            sink_hold = $urandom_range(50, 300);
        end else begin
            sink_hold--;
        end
        comb_phase = (comb_phase == 4) ? 0 : comb_phase + 1;
        case (sink_mode)
            SINK_OPEN: begin
                m_ready <= 1'b1;
            end
            SINK_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            SINK_SPARSE: begin
                m_ready <= ($urandom_range(0, 9) == 0);
            end
            default: begin
                m_ready <= (comb_phase >= 2);
            end
        endcase
    end

    task automatic check_field(input string field, input logic [CHANNEL_BITS-1:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor. Every result taken is matched against the oldest expectation.
    always @(posedge aclk) begin : hsv_monitor
        hsv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hsv.size() == 0) begin
                $error("unexpected result: hue %0d sat %0d val %0d",
                       m_data.hue_out, m_data.sat_out, m_data.val_out);
                mismatch_count++;
            end else begin
                want = expected_hsv.pop_front();
                check_field("hue_out", want.hue_out, m_data.hue_out);
                check_field("sat_out", want.sat_out, m_data.sat_out);
                check_field("val_out", want.val_out, m_data.val_out);
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        longint unsigned base, alt;
        int which;
        bit drain;

        // Directed pixels: black, white and grays, the primaries, every hue
        // sector on both sides of its branch, ties for the maximum, and the
        // corners of the channel range.
        add_pixel(0, 0, 0);
        add_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX);
        add_pixel(128, 128, 128);
        add_pixel(1, 1, 1);
        add_pixel(CHAN_MAX, 0, 0);
        add_pixel(0, CHAN_MAX, 0);
        add_pixel(0, 0, CHAN_MAX);
        add_pixel(CHAN_MAX, 0, 1);
        add_pixel(CHAN_MAX, 10, 0);
        add_pixel(200, 50, 50);
        add_pixel(30, 200, 90);
        add_pixel(90, 200, 30);
        add_pixel(90, 30, 200);
        add_pixel(30, 90, 200);
        add_pixel(200, 200, 10);
        add_pixel(10, 200, 200);
        add_pixel(200, 10, 200);
        add_pixel(1, 0, 0);
        add_pixel(0, 1, 0);
        add_pixel(0, 0, 1);
        add_pixel(CHAN_MAX, CHAN_MAX - 1, CHAN_MAX - 2);
        add_pixel(CHAN_MAX, 0, CHAN_MAX);
        add_pixel(0, CHAN_MAX, CHAN_MAX);
        add_pixel(CHAN_MAX, CHAN_MAX, 0);
        add_pixel(1, 0, CHAN_MAX);

        // Random pixels. Roughly a third are fully random; the rest favour
        // near-gray pixels, ties for the maximum and values at the range edges.
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            // The sender drains the pipeline completely a few times on the way.
            drain = (i == 0) || (i == 600) || (i == 1200);
            case ($urandom_range(0, 5))
                0, 1: begin
                    add_pixel(rand_chan(), rand_chan(), rand_chan(), drain);
                end
                2: begin
                    base = 64'($urandom_range(0, int'(CHAN_MAX) - 3));
                    add_pixel(base + 64'($urandom_range(0, 3)),
                              base + 64'($urandom_range(0, 3)),
                              base + 64'($urandom_range(0, 3)), drain);
                end
                3: begin
                    base  = rand_chan();
                    alt   = rand_chan();
                    which = $urandom_range(0, 2);
                    if (which == 0) add_pixel(base, base, alt, drain);
                    else if (which == 1) add_pixel(alt, base, base, drain);
                    else add_pixel(base, alt, base, drain);
                end
                4: begin
                    add_pixel(edge_chan(), edge_chan(), edge_chan(), drain);
                end
                default: begin
                    which = $urandom_range(0, 2);
                    if (which == 0) add_pixel(CHAN_MAX, 0, rand_chan(), drain);
                    else if (which == 1) add_pixel(rand_chan(), CHAN_MAX, 0, drain);
                    else add_pixel(0, rand_chan(), CHAN_MAX, drain);
                end
            endcase
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Every pixel has been sent once the queue is empty and valid has dropped;
        // then wait for the last results, and a little longer to catch strays.
        while (pixel_queue.size() != 0 || s_valid) @(posedge aclk);
        while (expected_hsv.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 20) @(posedge aclk);

        if (mismatch_count == 0 && expected_hsv.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
